// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define CET_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define CET_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/cet_pkg.sv =====
// ----------------------------------------------------------------------------
// cet_pkg
// Types and constants shared by the condition event trigger modules.
// ----------------------------------------------------------------------------
package cet_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = 1;
    localparam int unsigned QUEUE_LVL_W = 2;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned CFG_INDEX_W = 3;

    // Register indexes of the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TRIGGER_MODE      = 3'd0,
        REG_HOLD_SECONDS      = 3'd1,
        REG_CHANGE_THRESHOLD  = 3'd2,
        REG_SOURCE_IS_VAR     = 3'd3,
        REG_EVENT_TAG         = 3'd4
    } reg_index_t;

    // Trigger modes
    typedef enum logic [2:0] {
        MODE_CHANGE      = 3'd0,
        MODE_RISING      = 3'd1,
        MODE_FALLING     = 3'd2,
        MODE_STAYS_TRUE  = 3'd3,
        MODE_STAYS_FALSE = 3'd4
    } mode_t;

    // Work class assigned by the front end
    typedef enum logic [2:0] {
        OP_NOP,
        OP_CHG_FAIL,
        OP_CHG_SAMPLE,
        OP_EDGE,
        OP_HOLD_FAIL,
        OP_HOLD_STEP
    } op_t;

    typedef struct packed {
        logic               eval_ok;
        logic               cond_true;
        logic signed [31:0] sample_value;
        logic        [31:0] now_seconds;
    } sample_t;

    typedef struct packed {
        logic        fired;
        logic [15:0] fired_tag;
    } result_t;

    // One classified item in the queue; want is the target level
    typedef struct packed {
        op_t                op;
        logic               want;
        logic               cond_true;
        logic signed [31:0] sample_value;
        logic        [31:0] now_seconds;
    } queue_entry_t;

    typedef struct packed {
        logic                   empty;
        logic                   full;
        logic [QUEUE_LVL_W-1:0] level;
    } queue_status_t;

    typedef struct packed {
        logic        mode_wr;
        logic [2:0]  mode;
        logic [31:0] hold_seconds;
        logic [30:0] change_threshold;
        logic [15:0] event_tag;
    } back_cfg_t;

    function automatic logic mode_initial_flag(input logic [2:0] mode);
        return (mode == MODE_RISING) || (mode == MODE_STAYS_FALSE);
    endfunction

endpackage

// ===== rtl/core/cet_front.sv =====
// ----------------------------------------------------------------------------
// cet_front
// Accepts sample items and classifies them by trigger mode.
// ----------------------------------------------------------------------------
module cet_front
    import cet_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         sample_valid,
    output logic         sample_stall,
    input  sample_t      sample,
    input  logic [2:0]   trigger_mode,
    input  logic         source_is_variable,
    input  logic         queue_full,
    output logic         push,
    output queue_entry_t entry
);

    logic         valid_reg;
    logic         valid_next;
    queue_entry_t entry_reg;
    queue_entry_t entry_next;
    logic         accept;

    assign push         = valid_reg && !queue_full;
    assign sample_stall = valid_reg && queue_full;
    assign accept       = sample_valid && !sample_stall;
    assign entry        = entry_reg;

    always_comb
    begin
        entry_next.want         = 1'b0;
        entry_next.cond_true    = sample.cond_true;
        entry_next.sample_value = sample.sample_value;
        entry_next.now_seconds  = sample.now_seconds;
        entry_next.op           = OP_NOP;
        unique case (trigger_mode)
            MODE_CHANGE:
            begin
                if (source_is_variable)
                begin
                    entry_next.op = sample.eval_ok ? OP_CHG_SAMPLE : OP_CHG_FAIL;
                end
            end
            MODE_RISING, MODE_FALLING:
            begin
                entry_next.want = (trigger_mode == MODE_RISING);
                if (sample.eval_ok)
                begin
                    entry_next.op = OP_EDGE;
                end
            end
            MODE_STAYS_TRUE, MODE_STAYS_FALSE:
            begin
                entry_next.want = (trigger_mode == MODE_STAYS_TRUE);
                entry_next.op   = sample.eval_ok ? OP_HOLD_STEP : OP_HOLD_FAIL;
            end
            default:
            begin
                entry_next.op = OP_NOP;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

// ===== rtl/core/cet_queue.sv =====
// ----------------------------------------------------------------------------
// cet_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module cet_queue
    import cet_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  queue_entry_t  push_entry,
    input  logic          pop,
    output queue_entry_t  head,
    output queue_status_t status
);

    queue_entry_t           slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_LVL_W-1:0] level_reg;
    logic [QUEUE_LVL_W-1:0] level_next;

    assign head          = slot_reg[rd_ptr_reg];
    assign status.empty  = (level_reg == '0);
    assign status.full   = (level_reg == QUEUE_LVL_W'(QUEUE_DEPTH));
    assign status.level  = level_reg;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        level_next  = level_reg;
        if (push && !pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/core/cet_back.sv =====
// ----------------------------------------------------------------------------
// cet_back
// Executes classified items against trigger state; registered result.
// ----------------------------------------------------------------------------
module cet_back
    import cet_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  back_cfg_t    cfg,
    input  logic         queue_empty,
    input  queue_entry_t head,
    output logic         pop,
    output logic         result_valid,
    input  logic         result_stall,
    output result_t      result
);

    logic               result_valid_reg;
    logic               result_valid_next;
    result_t            result_reg;
    result_t            result_next;

    logic               last_flag_reg;
    logic               last_flag_next;
    logic signed [31:0] last_value_reg;
    logic signed [31:0] last_value_next;
    logic               already_fired_reg;
    logic               already_fired_next;
    logic        [31:0] level_start_reg;
    logic        [31:0] level_start_next;

    logic signed [32:0] chg_diff;
    logic        [32:0] chg_mag;
    logic               chg_hit;
    logic        [32:0] elapsed;
    logic               hold_met;
    logic               fire;

    assign pop          = !queue_empty && (!result_valid_reg || !result_stall);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // |sample - last| against threshold, 33 bits so nothing wraps
    assign chg_diff = {head.sample_value[31], head.sample_value}
                    - {last_value_reg[31], last_value_reg};
    assign chg_mag  = chg_diff[32] ? 33'(-chg_diff) : 33'(chg_diff);
    assign chg_hit  = chg_mag >= {2'b00, cfg.change_threshold};

    // signed elapsed time; negative never meets the hold
    assign elapsed  = {1'b0, head.now_seconds} - {1'b0, level_start_reg};
    assign hold_met = !elapsed[32] && (elapsed[31:0] >= cfg.hold_seconds);

    always_comb
    begin
        last_flag_next     = last_flag_reg;
        last_value_next    = last_value_reg;
        already_fired_next = already_fired_reg;
        level_start_next   = level_start_reg;
        fire               = 1'b0;

        if (pop)
        begin
            unique case (head.op)
                OP_CHG_FAIL:
                begin
                    last_flag_next = 1'b0;
                end
                OP_CHG_SAMPLE:
                begin
                    if (!last_flag_reg)
                    begin
                        last_flag_next  = 1'b1;
                        last_value_next = head.sample_value;
                    end
                    else if (chg_hit)
                    begin
                        fire            = 1'b1;
                        last_value_next = head.sample_value;
                    end
                end
                OP_EDGE:
                begin
                    fire = (head.cond_true == head.want) && (last_flag_reg != head.want);
                    last_flag_next = head.cond_true;
                end
                OP_HOLD_FAIL:
                begin
                    last_flag_next     = !head.want;
                    already_fired_next = 1'b0;
                    level_start_next   = '0;
                end
                OP_HOLD_STEP:
                begin
                    if ((head.cond_true == head.want) && (last_flag_reg == head.want)
                        && !already_fired_reg && hold_met)
                    begin
                        fire               = 1'b1;
                        already_fired_next = 1'b1;
                    end
                    else
                    begin
                        if (head.cond_true != head.want)
                        begin
                            already_fired_next = 1'b0;
                            level_start_next   = '0;
                        end
                        else if (last_flag_reg != head.want)
                        begin
                            level_start_next = head.now_seconds;
                        end
                        last_flag_next = head.cond_true;
                    end
                end
                default:
                begin
                    fire = 1'b0;
                end
            endcase
        end

        // mode write reloads the flag; the user must write it only while idle, this block does not enforce it
        if (cfg.mode_wr)
        begin
            last_flag_next = mode_initial_flag(cfg.mode);
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (pop)
        begin
            result_valid_next     = 1'b1;
            result_next.fired     = fire;
            result_next.fired_tag = cfg.event_tag;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg  <= 1'b0;
            last_flag_reg     <= 1'b0;
            last_value_reg    <= '0;
            already_fired_reg <= 1'b0;
            level_start_reg   <= '0;
        end
        else
        begin
            result_valid_reg  <= result_valid_next;
            last_flag_reg     <= last_flag_next;
            last_value_reg    <= last_value_next;
            already_fired_reg <= already_fired_next;
            level_start_reg   <= level_start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

// ===== rtl/core/condition_event_trigger.sv =====
// ----------------------------------------------------------------------------
// condition_event_trigger
// Change, edge and hold-time trigger on evaluated conditions, one result per item.
// ----------------------------------------------------------------------------
// Usage:
//   sample channel (sample_valid / sample_stall / sample) carries one
//   evaluation: success flag, boolean result, Q16.16 value, time in seconds.
//   result channel (result_valid / result_stall / result) returns exactly
//   one item per sample: fire flag and the configured event tag.
//   cfg_wr_en / cfg_index / cfg_data write the five registers; write only
//   while no item is in flight. Writing trigger_mode reloads the last flag.
// Timing:
//   result_valid rises once the item has passed the front register (loaded
//   on accept), the queue slot and then the result register; each of these
//   is registered. Throughput is one item per cycle while result_stall is
//   low, as the back end updates its state on each pop.
// Reset:
//   rst_n clears the queue, all trigger state and the registers to their
//   defaults (mode change, threshold 1, source is a variable).
// Stalls:
//   a stalled result holds; the two-entry queue keeps accepting until full,
//   then the front register fills and sample_stall rises.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module condition_event_trigger
    import cet_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    output logic                   sample_stall,
    input  sample_t                sample,
    output logic                   result_valid,
    input  logic                   result_stall,
    output result_t                result,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Configuration registers
    logic [2:0]  trigger_mode_reg;
    logic [31:0] hold_seconds_reg;
    logic [30:0] change_threshold_reg;
    logic        source_is_var_reg;
    logic [15:0] event_tag_reg;
    logic        mode_wr;

    // Front to queue
    logic          push;
    queue_entry_t  push_entry;
    // Queue to back
    queue_entry_t  head;
    queue_status_t q_status;
    logic          pop;
    back_cfg_t     back_cfg;

    assign mode_wr = cfg_wr_en && (cfg_index == REG_TRIGGER_MODE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_mode_reg     <= MODE_CHANGE;
            hold_seconds_reg     <= '0;
            change_threshold_reg <= 31'd1;
            source_is_var_reg    <= 1'b1;
            event_tag_reg        <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_TRIGGER_MODE:     trigger_mode_reg     <= cfg_data[2:0];
                REG_HOLD_SECONDS:     hold_seconds_reg     <= cfg_data;
                REG_CHANGE_THRESHOLD: change_threshold_reg <= cfg_data[30:0];
                REG_SOURCE_IS_VAR:    source_is_var_reg    <= cfg_data[0];
                REG_EVENT_TAG:        event_tag_reg        <= cfg_data[15:0];
                default:              ; // unused index, write dropped
            endcase
        end
    end

    // Back end sees the new mode in the same cycle it is written
    assign back_cfg.mode_wr          = mode_wr;
    assign back_cfg.mode             = cfg_data[2:0];
    assign back_cfg.hold_seconds     = hold_seconds_reg;
    assign back_cfg.change_threshold = change_threshold_reg;
    assign back_cfg.event_tag        = event_tag_reg;

    cet_front u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .sample_valid       (sample_valid),
        .sample_stall       (sample_stall),
        .sample             (sample),
        .trigger_mode       (trigger_mode_reg),
        .source_is_variable (source_is_var_reg),
        .queue_full         (q_status.full),
        .push               (push),
        .entry              (push_entry)
    );

    cet_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    cet_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (back_cfg),
        .queue_empty  (q_status.empty),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Queue never overfills, never pushes while full
    `CET_ASSERT(a_queue_level, clk, rst_n, q_status.level <= QUEUE_LVL_W'(QUEUE_DEPTH), "queue level above depth")
    `CET_ASSERT(a_push_not_full, clk, rst_n, push |-> !q_status.full, "push into full queue")
    // A fresh result always comes from a queue pop
    `CET_ASSERT(a_result_from_pop, clk, rst_n, $rose(result_valid) |-> $past(pop), "result without pop")
    // A waiting result blocks the back end from popping
    `CET_ASSERT_NEXT(a_stall_blocks_pop, clk, rst_n, result_valid && result_stall, !(result_valid && result_stall && pop), "pop while result stalled")

endmodule
